### sv/extended_gcd_coefficient_core_macros.svh
// Assertion macros used by the controller of the extended GCD coefficient core.
`ifndef EXTENDED_GCD_COEFFICIENT_CORE_MACROS_SVH
`define EXTENDED_GCD_COEFFICIENT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EGCD_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EGCD_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/egcd_pkg.sv
// Package: widths, controller states and control/status structs of the GCD core.
`timescale 1ns / 1ps
`default_nettype none
package egcd_pkg;

	localparam int OPERAND_WIDTH      = 31;
	localparam int COEFF_WIDTH        = 32;
	localparam int DATA_WIDTH_DEFAULT = 32;
	localparam int STEP_WIDTH         = $clog2(OPERAND_WIDTH);
	localparam logic [STEP_WIDTH-1:0] STEP_LAST = STEP_WIDTH'(OPERAND_WIDTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_step;
		logic update;
		logic capture;
	} ctrl_cmd_t;

	typedef struct packed {
		logic rem_zero;
	} dp_status_t;

endpackage
`default_nettype wire

### sv/egcd_if.sv
// Valid/ready channel interfaces for operand and coefficient transfers.
`timescale 1ns / 1ps
`default_nettype none
interface egcd_in_if;
	logic                                valid;
	logic                                ready;
	logic [egcd_pkg::OPERAND_WIDTH-1:0] operand_a;
	logic [egcd_pkg::OPERAND_WIDTH-1:0] operand_b;

	modport source (output valid, output operand_a, output operand_b, input ready);
	modport sink (input valid, input operand_a, input operand_b, output ready);
endinterface

interface egcd_out_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [egcd_pkg::COEFF_WIDTH-1:0] coefficient;

	modport source (output valid, output coefficient, input ready);
	modport sink (input valid, input coefficient, output ready);
endinterface
`default_nettype wire

### sv/egcd_ctrl.sv
// Controller FSM: sequences load, division steps, round update and result capture.
`timescale 1ns / 1ps
`default_nettype none
`include "extended_gcd_coefficient_core_macros.svh"
module egcd_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output      logic                 in_ready,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire egcd_pkg::dp_status_t status,
	output      egcd_pkg::ctrl_cmd_t  cmd
);

	egcd_pkg::state_t                   state_q, state_d;
	logic [egcd_pkg::STEP_WIDTH-1:0]   step_q;
	logic                               out_valid_q;
	logic                               slot_free;

	assign slot_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			egcd_pkg::ST_IDLE: begin
				if (in_valid) state_d = egcd_pkg::ST_CHECK;
			end
			egcd_pkg::ST_CHECK: begin
				if (!status.rem_zero) state_d = egcd_pkg::ST_DIV;
				else if (slot_free) state_d = egcd_pkg::ST_IDLE;
			end
			egcd_pkg::ST_DIV: begin
				if (step_q == egcd_pkg::STEP_LAST) state_d = egcd_pkg::ST_UPDATE;
			end
			egcd_pkg::ST_UPDATE: state_d = egcd_pkg::ST_CHECK;
			default: state_d = egcd_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			egcd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			egcd_pkg::ST_CHECK: begin
				cmd.div_start = !status.rem_zero;
				cmd.capture   = status.rem_zero && slot_free;
			end
			egcd_pkg::ST_DIV:    cmd.div_step = 1'b1;
			egcd_pkg::ST_UPDATE: cmd.update   = 1'b1;
			default: cmd = '0;
		endcase
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= egcd_pkg::ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_start) step_q <= '0;
			else if (cmd.div_step) step_q <= step_q + 1'b1;
			if (cmd.capture) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	`EGCD_ASSERT_NEXT(a_accept_to_check, clk, arst_n, in_valid && in_ready, state_q == egcd_pkg::ST_CHECK, "accepted operands did not start a round check")
	`EGCD_ASSERT_NOW(a_capture_slot, clk, arst_n, cmd.capture, !out_valid_q || out_ready, "result captured over an untaken result")
	`EGCD_ASSERT_NOW(a_capture_done, clk, arst_n, cmd.capture, status.rem_zero, "result captured before remainder reached zero")
	`EGCD_ASSERT_NEXT(a_div_length, clk, arst_n, cmd.div_step && step_q == egcd_pkg::STEP_LAST, state_q == egcd_pkg::ST_UPDATE && cmd.update, "division did not end after its last step")

endmodule
`default_nettype wire

### sv/egcd_dp.sv
// Datapath: remainder and s registers, radix-2 divider with shift-and-add product.
`timescale 1ns / 1ps
`default_nettype none
module egcd_dp #(
	parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEFAULT
) (
	input  wire logic                                    clk,
	input  wire egcd_pkg::ctrl_cmd_t                     cmd,
	input  wire logic [egcd_pkg::OPERAND_WIDTH-1:0]      operand_a,
	input  wire logic [egcd_pkg::OPERAND_WIDTH-1:0]      operand_b,
	output      logic signed [egcd_pkg::COEFF_WIDTH-1:0] coefficient,
	output      egcd_pkg::dp_status_t                    status
);

	localparam int N  = egcd_pkg::OPERAND_WIDTH;
	localparam int CW = egcd_pkg::COEFF_WIDTH;

	logic [N-1:0]            rem_prev_q, rem_cur_q, dvd_q, part_q;
	logic [DATA_WIDTH-1:0]   s_prev_q, s_cur_q, prod_q;
	logic signed [CW-1:0]    coeff_q;
	logic [N:0]              shifted;
	logic [N+1:0]            diff;
	logic                    q_bit;
	logic signed [DATA_WIDTH-1:0] s_sx;

	// one restoring division step
	assign shifted = {part_q, dvd_q[N-1]};
	assign diff    = {1'b0, shifted} - {2'b00, rem_cur_q};
	assign q_bit   = !diff[N+1];
	assign s_sx    = s_prev_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_prev_q <= operand_a;
			rem_cur_q  <= operand_b;
			s_prev_q   <= {{(DATA_WIDTH-1){1'b0}}, 1'b1};
			s_cur_q    <= '0;
		end
		if (cmd.div_start) begin
			dvd_q  <= rem_prev_q;
			part_q <= '0;
			prod_q <= '0;
		end
		if (cmd.div_step) begin
			dvd_q  <= dvd_q << 1;
			part_q <= q_bit ? diff[N-1:0] : shifted[N-1:0];
			prod_q <= (prod_q << 1) + (q_bit ? s_cur_q : '0);
		end
		if (cmd.update) begin
			rem_prev_q <= rem_cur_q;
			rem_cur_q  <= part_q;
			s_prev_q   <= s_cur_q;
			s_cur_q    <= s_prev_q - prod_q;
		end
		if (cmd.capture) coeff_q <= CW'(s_sx);
	end

	assign status.rem_zero = (rem_cur_q == '0);
	assign coefficient     = coeff_q;

endmodule
`default_nettype wire

### sv/extended_gcd_coefficient_core.sv
// Top level of the extended GCD coefficient core: controller plus datapath.
// Each Euclid round is a check state, the steps of the one-bit-per-cycle divider
// and an update state.
// Throughput: one item at a time; the next operands transfer while a result waits.
// Reset (arst_n low) clears the controller state and the result-valid flag only.
`timescale 1ns / 1ps
`default_nettype none
module extended_gcd_coefficient_core #(
	parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEFAULT
) (
	input wire logic     clk,
	input wire logic     arst_n,
	egcd_in_if.sink      operands,
	egcd_out_if.source   result
);

	// commands from the controller, status back from the datapath
	egcd_pkg::ctrl_cmd_t  cmd;
	egcd_pkg::dp_status_t status;

	logic                                     in_ready;
	logic                                     out_valid;
	logic signed [egcd_pkg::COEFF_WIDTH-1:0] coefficient;

	// Controller: accepts operands in idle, walks check/divide/update rounds
	// and holds the result valid until the sink takes the transfer.
	egcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operands.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: remainders, s sequence wrapped to DATA_WIDTH bits,
	// divider and the q * s product built bit by bit during division.
	egcd_dp #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.operand_a   (operands.operand_a),
		.operand_b   (operands.operand_b),
		.coefficient (coefficient),
		.status      (status)
	);

	assign operands.ready     = in_ready;
	assign result.valid       = out_valid;
	assign result.coefficient = coefficient;

endmodule
`default_nettype wire

### dv/tb.sv
// Testbench for the extended GCD coefficient core: random and directed operand checks.
`timescale 1ns / 1ps
module tb;

	import egcd_pkg::*;

	// Working width of the s sequence; the DUT is built with the same value.
	localparam int WORK_WIDTH   = DATA_WIDTH_DEFAULT;
	localparam int RANDOM_ITEMS = 400;
	// Cycle limit of the watchdog for the whole run; allow several times the slowest run.
	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int SETTLE_CYCLES = 1600;
	localparam int LONG_HOLD    = 4000;
	localparam logic [OPERAND_WIDTH-1:0] OPERAND_MAX = '1;

	typedef struct {
		logic [OPERAND_WIDTH-1:0] a;
		logic [OPERAND_WIDTH-1:0] b;
		bit                       drain_first;
	} operand_pair_t;

	typedef struct {
		logic [OPERAND_WIDTH-1:0]       a;
		logic [OPERAND_WIDTH-1:0]       b;
		logic signed [COEFF_WIDTH-1:0]  coeff;
	} coeff_expect_t;

	logic clk;
	logic arst_n;

	egcd_in_if  operands_ch ();
	egcd_out_if result_ch ();

	extended_gcd_coefficient_core #(
		.DATA_WIDTH(WORK_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.operands(operands_ch),
		.result(result_ch)
	);

	operand_pair_t pending_pairs[$];
	coeff_expect_t coeff_expected[$];

	int unsigned fib [0:46];
	int          error_count;
	int          results_seen;
	int          cycle_count;

	// Driver bookkeeping, touched only by the driver process.
	bit offering;
	int burst_left;
	int gap_left;

	// Receiver bookkeeping, touched only by the monitor process.
	int hold_left;
	int stall_left;
	int calm_left;

	// Bezout coefficient of a: run Euclid with truncating division, carry s modulo
	// 2^WORK_WIDTH, then sign-extend the last nonzero-remainder s into 32 bits.
	function automatic logic signed [COEFF_WIDTH-1:0] bezout_coeff_of(
		logic [OPERAND_WIDTH-1:0] a,
		logic [OPERAND_WIDTH-1:0] b
	);
		longint unsigned rem_prev;
		longint unsigned rem_cur;
		longint unsigned quot;
		longint unsigned rem_next;
		logic signed [WORK_WIDTH-1:0] s_prev;
		logic signed [WORK_WIDTH-1:0] s_cur;
		logic signed [WORK_WIDTH-1:0] s_next;
		rem_prev = 64'(a);
		rem_cur  = 64'(b);
		s_prev   = 1;
		s_cur    = 0;
		while (rem_cur != 0) begin
			quot     = rem_prev / rem_cur;
			rem_next = rem_prev - quot * rem_cur;
			s_next   = s_prev - WORK_WIDTH'(quot) * s_cur;
			rem_prev = rem_cur;
			rem_cur  = rem_next;
			s_prev   = s_cur;
			s_cur    = s_next;
		end
		return COEFF_WIDTH'(s_prev);
	endfunction

	function automatic logic [OPERAND_WIDTH-1:0] rand_operand();
		return OPERAND_WIDTH'($urandom());
	endfunction

	task automatic add_pair(logic [OPERAND_WIDTH-1:0] a, logic [OPERAND_WIDTH-1:0] b,
			bit drain_first = 1'b0);
		operand_pair_t p;
		p.a = a;
		p.b = b;
		p.drain_first = drain_first;
		pending_pairs.push_back(p);
	endtask

	// Random pair shaped toward interesting behavior: long Euclid chains, exact
	// multiples, zero operands and small values alongside plain random words.
	task automatic add_random_pair(bit drain_first);
		int unsigned mode;
		int unsigned k;
		logic [OPERAND_WIDTH-1:0] a;
		logic [OPERAND_WIDTH-1:0] b;
		mode = $urandom_range(0, 9);
		case (mode)
			5: begin
				a = OPERAND_WIDTH'($urandom_range(0, 255));
				b = OPERAND_WIDTH'($urandom_range(0, 255));
			end
			6: begin
				a = rand_operand();
				b = OPERAND_WIDTH'($urandom_range(1, 1000));
			end
			7: begin
				a = rand_operand();
				case ($urandom_range(0, 2))
					0: b = 0;
					1: begin
						b = a;
						a = 0;
					end
					default: b = a;
				endcase
			end
			8: begin
				k = $urandom_range(2, 46);
				if ($urandom_range(0, 1)) begin
					a = OPERAND_WIDTH'(fib[k]);
					b = OPERAND_WIDTH'(fib[k-1]);
				end else begin
					a = OPERAND_WIDTH'(fib[k-1]);
					b = OPERAND_WIDTH'(fib[k]);
				end
			end
			9: begin
				b = OPERAND_WIDTH'($urandom_range(1, 65535));
				a = OPERAND_WIDTH'({1'b0, b} * $urandom_range(1, 32767));
			end
			default: begin
				a = rand_operand();
				b = rand_operand();
			end
		endcase
		add_pair(a, b, drain_first);
	endtask

	task automatic report_mismatch(string what);
		error_count++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Clock: 10 ns period.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold every DUT input at a known value from time zero, then release reset
	// on a rising edge of the clock.
	initial begin
		arst_n                = 1'b0;
		operands_ch.valid     = 1'b0;
		operands_ch.operand_a = '0;
		operands_ch.operand_b = '0;
		result_ch.ready       = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Stimulus and end of run.
	initial begin
		fib[0] = 0;
		fib[1] = 1;
		for (int i = 2; i <= 46; i++) begin
			fib[i] = fib[i-1] + fib[i-2];
		end

		// Directed: zero operands, both extremes, the longest Euclid chain
		// (consecutive Fibonacci numbers) and a few textbook inverses.
		add_pair(0, 0);
		add_pair(0, 1);
		add_pair(0, OPERAND_MAX);
		add_pair(1, 0);
		add_pair(OPERAND_MAX, 0);
		add_pair(1, 1);
		add_pair(OPERAND_MAX, OPERAND_MAX);
		add_pair(OPERAND_MAX, 1);
		add_pair(1, OPERAND_MAX);
		add_pair(OPERAND_MAX, OPERAND_MAX - 1);
		add_pair(OPERAND_MAX - 1, OPERAND_MAX);
		add_pair(OPERAND_WIDTH'(fib[46]), OPERAND_WIDTH'(fib[45]));
		add_pair(OPERAND_WIDTH'(fib[45]), OPERAND_WIDTH'(fib[46]));
		add_pair(3, 7);
		add_pair(7, 3);
		add_pair(12, 18);
		add_pair(240, 46);
		add_pair(2, OPERAND_MAX);
		add_pair(1234567, OPERAND_MAX);
		add_pair(31'h2AAAAAAA, 31'h55555555);

		// Random part; twice the sender waits for the pipeline to empty first.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			add_random_pair(i == 100 || i == 300);
		end

		// Wait for every pair to transfer and every coefficient to come back.
		@(posedge clk);
		while (pending_pairs.size() != 0 || coeff_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (coeff_expected.size() != 0) begin
			report_mismatch($sformatf("%0d coefficients never arrived", coeff_expected.size()));
		end
		if (error_count == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	// Driver: offer pending pairs in bursts of random length with random gaps.
	// Keep valid and the payload steady until the transfer happens; record the
	// predicted coefficient at the transfer edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operands_ch.valid <= 1'b0;
			offering   = 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (offering && operands_ch.ready) begin
				coeff_expected.push_back('{
					a:     operands_ch.operand_a,
					b:     operands_ch.operand_b,
					coeff: bezout_coeff_of(operands_ch.operand_a, operands_ch.operand_b)
				});
				void'(pending_pairs.pop_front());
				offering = 1'b0;
			end
			if (!offering) begin
				if (gap_left > 0) begin
					gap_left--;
					operands_ch.valid <= 1'b0;
				end else if (pending_pairs.size() != 0 &&
						(!pending_pairs[0].drain_first || coeff_expected.size() == 0)) begin
					operands_ch.valid     <= 1'b1;
					operands_ch.operand_a <= pending_pairs[0].a;
					operands_ch.operand_b <= pending_pairs[0].b;
					offering = 1'b1;
					if (burst_left <= 1) begin
						// Start a fresh burst; about a third of bursts follow without a gap.
						burst_left = $urandom_range(1, 16);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
					end else begin
						burst_left--;
					end
				end else begin
					operands_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each coefficient transfer with the oldest prediction and
	// drive ready from its own stall pattern, with two long hold-offs that back
	// the core up into its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left  = 0;
			stall_left = 0;
			calm_left  = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (coeff_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected coefficient %0d",
						result_ch.coefficient));
				end else begin
					if (result_ch.coefficient !== coeff_expected[0].coeff) begin
						report_mismatch($sformatf("a=%0d b=%0d coefficient got %0d want %0d",
							coeff_expected[0].a, coeff_expected[0].b,
							result_ch.coefficient, coeff_expected[0].coeff));
					end
					void'(coeff_expected.pop_front());
				end
				results_seen++;
				if (results_seen == 30 || results_seen == 200) begin
					hold_left = LONG_HOLD;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (calm_left > 0) begin
				calm_left--;
				result_ch.ready <= 1'b1;
			end else begin
				// Pick the next phase: a stretch of steady ready or a short stall.
				if ($urandom_range(0, 3) == 0) begin
					calm_left = $urandom_range(50, 3000);
					result_ch.ready <= 1'b1;
				end else begin
					stall_left = $urandom_range(0, 30);
					result_ch.ready <= 1'b0;
				end
			end
		end
	end

	// Watchdog: end the run as failed once the cycle count passes CYCLE_LIMIT.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

endmodule
